// ===== hdl/tilt_angle_kalman_filter_top_defines.svh =====
// Assertion macros for the tilt angle Kalman filter.
// Taken in by the modules that carry concurrent assertions; needs nothing else.
`ifndef TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define TAKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("takf assertion failed");

// next-cycle implication
`define TAKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("takf assertion failed");

`endif

// ===== hdl/takf_pkg.sv =====
// Shared types, constants and fixed-point helpers of the tilt angle Kalman filter.
// No dependencies.
`timescale 1ns / 1ps

package takf_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W  = 31;
	localparam int DT_W   = 24;
	localparam int FRAC   = 24;
	localparam int OPD_W  = 33;
	localparam int PROD_W = 66;
	localparam int RND_W  = 42;
	localparam int ACC_W  = 44;
	localparam int NUM_W  = 56;
	localparam int DEN_W  = 33;
	localparam int CNT_W  = 6;

	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd503316;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 44'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_MIN = -44'sd2147483648;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		REG_ANGLE_NOISE = 2'd0,
		REG_BIAS_NOISE  = 2'd1,
		REG_MEAS_NOISE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		word_t ang;
		word_t bias;
		word_t caa;
		word_t cab;
		word_t cba;
		word_t cbb;
	} axis_state_t;

	typedef struct packed {
		logic             start;
		logic             neg;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		word_t quo;
	} div_rsp_t;

	function automatic logic signed [ACC_W-1:0] sx32(input word_t w);
		return {{(ACC_W-WORD_W){w[WORD_W-1]}}, w};
	endfunction

	function automatic logic signed [ACC_W-1:0] sx42(input logic signed [RND_W-1:0] w);
		return {{(ACC_W-RND_W){w[RND_W-1]}}, w};
	endfunction

	function automatic word_t sat32(input logic signed [ACC_W-1:0] v);
		word_t r;
		if (v > ACC_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < ACC_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	// scale by 2^-24, round to nearest with ties up
	function automatic logic signed [RND_W-1:0] round_q24(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + (PROD_W'(1) <<< (FRAC - 1));
		return t[PROD_W-1:FRAC];
	endfunction

endpackage

// ===== hdl/takf_sample_if.sv =====
// Input channel of the tilt angle Kalman filter: one sample per transfer.
// Depends on takf_pkg.
`timescale 1ns / 1ps

interface takf_sample_if;
	import takf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    axis_sel;
	logic signed [WORD_W-1:0] measured_angle;
	logic signed [WORD_W-1:0] measured_rate;
	logic [DT_W-1:0]          step_time;

	modport source (output valid, axis_sel, measured_angle, measured_rate, step_time,
		input ready);
	modport sink (input valid, axis_sel, measured_angle, measured_rate, step_time,
		output ready);
endinterface

// ===== hdl/takf_result_if.sv =====
// Output channel of the tilt angle Kalman filter: one filtered angle per transfer.
// Depends on takf_pkg.
`timescale 1ns / 1ps

interface takf_result_if;
	import takf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     axis_out;
	logic signed [WORD_W-1:0] filtered_angle;

	modport source (output valid, axis_out, filtered_angle, input ready);
	modport sink (input valid, axis_out, filtered_angle, output ready);
endinterface

// ===== hdl/tilt_angle_kalman_filter_top.sv =====
// Channel   Dir  Handshake      Payload
// sample    in   valid/ready    axis_sel, measured_angle, measured_rate, step_time
// result    out  valid/ready    axis_out, filtered_angle
// cfg       in   cfg_we         cfg_index, cfg_data (noise registers)
//
// One sample at a time: each takes eleven passes through the shared multiplier and,
// when the gain denominator is positive, two divisions for the gains.
// An out-of-range axis returns a zero angle and leaves state alone.
// Per-axis state sits in one memory; valid bits cleared by reset make it read zero.
// A waiting result holds the block in its last step; no further sample is taken.
// Depends on takf_pkg, takf_sample_if, takf_result_if, takf_div and the defines header.
`timescale 1ns / 1ps
`include "tilt_angle_kalman_filter_top_defines.svh"

module tilt_angle_kalman_filter_top import takf_pkg::*; #(
	parameter int NUM_AXES = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	takf_sample_if.sink       sample,
	takf_result_if.source     result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	localparam logic [3:0] MS_RATE = 4'd0;
	localparam logic [3:0] MS_CROSS = 4'd1;
	localparam logic [3:0] MS_QANG = 4'd2;
	localparam logic [3:0] MS_CBB = 4'd3;
	localparam logic [3:0] MS_QBIAS = 4'd4;
	localparam logic [3:0] MS_KANG = 4'd5;
	localparam logic [3:0] MS_KBIAS = 4'd6;
	localparam logic [3:0] MS_KCAA = 4'd7;
	localparam logic [3:0] MS_KCAB = 4'd8;
	localparam logic [3:0] MS_KCBA = 4'd9;
	localparam logic [3:0] MS_KCBB = 4'd10;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] apn_q, bpn_q, mn_q;

	axis_state_t      mem_q [NUM_AXES];
	logic [NUM_AXES-1:0] vld_q;
	axis_state_t      rd_s1;
	logic             vld_s1;
	axis_state_t      cur;
	logic [AW-1:0]    in_addr;
	logic             accept;

	logic             axis_q;
	logic             in_range_q;
	word_t            z_q, rate_q;
	logic [DT_W-1:0]  dt_q;

	logic [3:0]       mi_q;
	logic [1:0]       ph_q;
	logic signed [OPD_W-1:0]  opa, opb, mul_a_s1, mul_b_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  r;

	logic signed [RND_W-1:0] t0_q;
	word_t ang_q, p00_q, p01_q, p10_q, p11_q, y_q, k0_q, k1_q;
	logic signed [DEN_W:0]   s_q;
	logic signed [ACC_W-1:0] s_sum;
	axis_state_t nxt_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     ksel_q;
	logic     start_q;
	logic     neg_q;
	logic [NUM_W-1:0] num_q;

	logic out_valid_q;
	logic out_axis_q;
	word_t out_angle_q;
	logic out_load;

	function automatic logic [NUM_W-1:0] mag_num(input word_t w);
		logic [WORD_W-1:0] a;
		a = w[WORD_W-1] ? WORD_W'(-w) : WORD_W'(w);
		return {a, {FRAC{1'b0}}};
	endfunction

	assign accept   = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign in_addr  = AW'(sample.axis_sel);
	assign cur      = vld_s1 ? rd_s1 : '0;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apn_q <= ANGLE_NOISE_RST;
			bpn_q <= BIAS_NOISE_RST;
			mn_q  <= MEAS_NOISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_NOISE: apn_q <= cfg_data;
				REG_BIAS_NOISE:  bpn_q <= cfg_data;
				REG_MEAS_NOISE:  mn_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// state memory: read on transfer, write back once the update is complete
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem_q[in_addr];
		end
		if (state_q == ST_WRITE) begin
			mem_q[AW'(axis_q)] <= nxt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= vld_q[in_addr];
			end
			if (state_q == ST_WRITE) begin
				vld_q[AW'(axis_q)] <= 1'b1;
			end
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (mi_q)
			MS_RATE: begin
				opa = {9'b0, dt_q};
				opb = {rate_q[WORD_W-1], rate_q} - {cur.bias[WORD_W-1], cur.bias};
			end
			MS_CROSS: begin
				opa = {9'b0, dt_q};
				opb = {cur.cba[WORD_W-1], cur.cba} + {cur.cab[WORD_W-1], cur.cab};
			end
			MS_QANG: begin
				opa = {2'b0, apn_q};
				opb = {9'b0, dt_q};
			end
			MS_CBB: begin
				opa = {9'b0, dt_q};
				opb = {cur.cbb[WORD_W-1], cur.cbb};
			end
			MS_QBIAS: begin
				opa = {2'b0, bpn_q};
				opb = {9'b0, dt_q};
			end
			MS_KANG: begin
				opa = {k0_q[WORD_W-1], k0_q};
				opb = {y_q[WORD_W-1], y_q};
			end
			MS_KBIAS: begin
				opa = {k1_q[WORD_W-1], k1_q};
				opb = {y_q[WORD_W-1], y_q};
			end
			MS_KCAA: begin
				opa = {k0_q[WORD_W-1], k0_q};
				opb = {p00_q[WORD_W-1], p00_q};
			end
			MS_KCAB: begin
				opa = {k0_q[WORD_W-1], k0_q};
				opb = {p01_q[WORD_W-1], p01_q};
			end
			MS_KCBA: begin
				opa = {k1_q[WORD_W-1], k1_q};
				opb = {p00_q[WORD_W-1], p00_q};
			end
			MS_KCBB: begin
				opa = {k1_q[WORD_W-1], k1_q};
				opb = {p01_q[WORD_W-1], p01_q};
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign r     = sx42(round_q24(prod_s2));
	assign s_sum = sx32(p00_q) + $signed({13'b0, mn_q});

	always_ff @(posedge clk) begin
		mul_a_s1 <= opa;
		mul_b_s1 <= opb;
		prod_s2  <= mul_a_s1 * mul_b_s1;
	end

	// pulse a divider start for each gain when the denominator is positive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= (state_q == ST_MUL && ph_q == 2'd2 && mi_q == MS_QBIAS && s_q > 0)
				|| (state_q == ST_DIV && div_rsp.done && !ksel_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mi_q        <= MS_RATE;
			ph_q        <= '0;
			ksel_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mi_q <= MS_RATE;
						ph_q <= '0;
						state_q <= (32'(sample.axis_sel) < NUM_AXES) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 1'b1;
					end else begin
						ph_q <= '0;
						if (mi_q == MS_QBIAS) begin
							if (s_q > 0) begin
								ksel_q  <= 1'b0;
								state_q <= ST_DIV;
							end else begin
								mi_q <= MS_KANG;
							end
						end else if (mi_q == MS_KCBB) begin
							state_q <= ST_WRITE;
						end else begin
							mi_q <= mi_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (!ksel_q) begin
							ksel_q  <= 1'b1;
						end else begin
							mi_q    <= MS_KANG;
							state_q <= ST_MUL;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q     <= sample.axis_sel;
			in_range_q <= (32'(sample.axis_sel) < NUM_AXES);
			z_q        <= sample.measured_angle;
			rate_q     <= sample.measured_rate;
			dt_q       <= sample.step_time;
			k0_q       <= '0;
			k1_q       <= '0;
			nxt_q      <= '0;
		end
		if (state_q == ST_MUL && ph_q == 2'd2) begin
			case (mi_q)
				MS_RATE:  ang_q <= sat32(sx32(cur.ang) + r);
				MS_CROSS: begin
					t0_q <= r[RND_W-1:0];
					y_q  <= sat32(sx32(z_q) - sx32(ang_q));
				end
				MS_QANG:  p00_q <= sat32(sx32(cur.caa) - sx42(t0_q) + r);
				MS_CBB: begin
					p01_q <= sat32(sx32(cur.cab) - r);
					p10_q <= sat32(sx32(cur.cba) - r);
					s_q   <= s_sum[DEN_W:0];
				end
				MS_QBIAS: begin
					p11_q <= sat32(sx32(cur.cbb) + r);
					neg_q <= p00_q[WORD_W-1];
					num_q <= mag_num(p00_q);
				end
				MS_KANG:  nxt_q.ang  <= sat32(sx32(ang_q) + r);
				MS_KBIAS: nxt_q.bias <= sat32(sx32(cur.bias) + r);
				MS_KCAA:  nxt_q.caa  <= sat32(sx32(p00_q) - r);
				MS_KCAB:  nxt_q.cab  <= sat32(sx32(p01_q) - r);
				MS_KCBA:  nxt_q.cba  <= sat32(sx32(p10_q) - r);
				MS_KCBB:  nxt_q.cbb  <= sat32(sx32(p11_q) - r);
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			if (!ksel_q) begin
				k0_q  <= div_rsp.quo;
				neg_q <= p10_q[WORD_W-1];
				num_q <= mag_num(p10_q);
			end else begin
				k1_q <= div_rsp.quo;
			end
		end
		if (out_load) begin
			out_axis_q  <= axis_q;
			out_angle_q <= in_range_q ? nxt_q.ang : '0;
		end
	end

	assign div_req.start = start_q;
	assign div_req.neg   = neg_q;
	assign div_req.num   = num_q;
	assign div_req.den   = s_q[DEN_W-1:0];

	takf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign result.valid          = out_valid_q;
	assign result.axis_out       = out_axis_q;
	assign result.filtered_angle = out_angle_q;

	`TAKF_ASSERT_NXT(a_transfer_starts_work, clk, arst_n, accept, state_q != ST_IDLE)
	`TAKF_ASSERT_IMP(a_div_busy_in_div, clk, arst_n, div_rsp.busy, state_q == ST_DIV)
	`TAKF_ASSERT_IMP(a_write_in_range, clk, arst_n, state_q == ST_WRITE, in_range_q)
	`TAKF_ASSERT_NXT(a_done_loads_result, clk, arst_n, out_load, out_valid_q && state_q == ST_IDLE)

endmodule

// ===== hdl/takf_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Kalman gains.
// Depends on takf_pkg; quotient truncates toward zero and saturates to 32 bits.
`timescale 1ns / 1ps

module takf_div import takf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	word_t            quo_sat;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.num;
			quo_q <= '0;
			den_q <= req.den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (quo_q > NUM_W'(64'h8000_0000)) begin
				quo_sat = 32'sh80000000;
			end else begin
				quo_sat = -$signed(quo_q[WORD_W-1:0]);
			end
		end else begin
			if (quo_q > NUM_W'(64'h7fff_ffff)) begin
				quo_sat = 32'sh7fffffff;
			end else begin
				quo_sat = $signed(quo_q[WORD_W-1:0]);
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_sat;

endmodule
